[hdl/lzss_pkg.sv]
// shared constants for the lzss ring decoder
`default_nettype none
package lzss_pkg;
  localparam int COUNT_BITS = 24;
  localparam int LIMIT_W = 24;
  localparam int RING_SIZE = 4096;
  localparam int RING_AW = $clog2(RING_SIZE);
  localparam int MAX_COPY = 18;
  localparam int MIN_COPY = 3;
  localparam int REM_W = $clog2(MAX_COPY + 1);
  localparam int FILL_W = RING_AW + 1;
  localparam logic [RING_AW-1:0] RING_START = RING_AW'(RING_SIZE - MAX_COPY);
  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_BITS) - 64'd1);

  // token phase codes
  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
endpackage
`default_nettype wire

[hdl/lzss_ring_decoder.sv]
// lzss decoder with a 4096-byte history ring in one synchronous memory
//
//   channel   handshake                 payload
//   input     in_valid / in_ready       in_byte, last_input
//   output    out_valid / out_ready     out_byte, run_last, limit_reached, produced_count
//   config    output_limit_we           output_limit_wdata
//
// flag bytes and reference low bytes are taken in the idle state alone, a literal also passes S_LIT
// a reference then steps through S_READ, a ring read, and S_DATA, an emit and ring write,
// for each copied byte (read data is registered and a read may need the byte just written)
// unwritten ring entries read as zero through a fill count, so no clearing pass
// a stalled output holds the emit step; input waits until the item is done
`default_nettype none
module lzss_ring_decoder
  import lzss_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  input  wire logic                last_input,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     run_last,
  output logic                     limit_reached,
  output logic [LIMIT_W-1:0]       produced_count,
  input  wire logic                output_limit_we,
  input  wire logic [LIMIT_W-1:0]  output_limit_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  logic [1:0]            state;
  logic [1:0]            phase;
  logic [8:0]            flag_shift;
  logic [7:0]            held_low;
  logic [7:0]            lit_byte;
  logic [RING_AW-1:0]    wpos;
  logic [RING_AW-1:0]    rd_addr;
  logic [REM_W-1:0]      rem;
  logic [FILL_W-1:0]     fill;
  logic [COUNT_BITS-1:0] byte_count;
  logic                  stopped;
  logic                  last_pend;
  logic [LIMIT_W-1:0]    output_limit;

  logic [7:0]            ring [RING_SIZE];
  logic [7:0]            rdata;
  logic                  rd_ok;

  logic                  in_fire;
  logic                  slot_free;
  logic                  emit_en;
  logic [7:0]            emit_data;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CMP_W-1:0]      count_inc_ext;
  logic [CMP_W-1:0]      eff_limit;
  logic                  reached;
  logic                  at_limit;
  logic [8:0]            shift_next;
  logic [1:0]            phase_next;
  logic [RING_AW-1:0]    rd_rel;
  logic                  rd_written;
  logic                  copy_done;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign emit_en   = ((state == S_LIT) || (state == S_DATA)) && slot_free;

  always_comb begin
    if (CMP_W'(output_limit) > COUNT_MAX) begin
      eff_limit = COUNT_MAX;
    end else begin
      eff_limit = CMP_W'(output_limit);
    end
    count_inc     = byte_count + COUNT_BITS'(1);
    count_inc_ext = CMP_W'(count_inc);
    reached       = count_inc_ext >= eff_limit;
    at_limit      = CMP_W'(byte_count) >= eff_limit;
    emit_data     = (state == S_LIT) ? lit_byte : (rd_ok ? rdata : 8'h00);
    shift_next    = flag_shift >> 1;
    phase_next    = (shift_next <= 9'd1) ? PH_FLAG : PH_TOKEN;
    // ring is written in order from the start position, so fill tells what is valid
    rd_rel        = rd_addr - RING_START;
    rd_written    = {1'b0, rd_rel} < fill;
    copy_done     = reached || (rem == REM_W'(1));
  end

  // history ring, read data registered
  always_ff @(posedge clk) begin
    if (emit_en) begin
      ring[wpos] <= emit_data;
    end
    if (state == S_READ) begin
      rdata <= ring[rd_addr];
      rd_ok <= rd_written;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_W'(24'hFFFFFF);
    end else if (output_limit_we) begin
      output_limit <= output_limit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_FLAG;
      flag_shift <= '0;
      held_low   <= '0;
      wpos       <= RING_START;
      fill       <= '0;
      byte_count <= '0;
      stopped    <= 1'b0;
      last_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_en) begin
        out_valid  <= 1'b1;
        wpos       <= wpos + RING_AW'(1);
        byte_count <= count_inc;
        if (fill != FILL_W'(RING_SIZE)) begin
          fill <= fill + FILL_W'(1);
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && !stopped) begin
            if (at_limit) begin
              stopped <= 1'b1;
            end else begin
              case (phase)
                PH_TOKEN: begin
                  if (flag_shift[0]) begin
                    lit_byte  <= in_byte;
                    last_pend <= last_input;
                    state     <= S_LIT;
                  end else begin
                    held_low <= in_byte;
                    phase    <= PH_HIGH;
                    stopped  <= last_input;
                  end
                end
                PH_HIGH: begin
                  rd_addr   <= {in_byte[7:4], held_low};
                  rem       <= REM_W'(in_byte[3:0]) + REM_W'(MIN_COPY);
                  last_pend <= last_input;
                  state     <= S_READ;
                end
                default: begin
                  flag_shift <= {1'b1, in_byte};
                  phase      <= PH_TOKEN;
                  stopped    <= last_input;
                end
              endcase
            end
          end
        end
        S_LIT: begin
          if (slot_free) begin
            flag_shift <= shift_next;
            phase      <= phase_next;
            stopped    <= reached || last_pend;
            state      <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (slot_free) begin
            if (copy_done) begin
              flag_shift <= shift_next;
              phase      <= phase_next;
              stopped    <= reached || last_pend;
              state      <= S_IDLE;
            end else begin
              rem     <= rem - REM_W'(1);
              rd_addr <= rd_addr + RING_AW'(1);
              state   <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_byte       <= emit_data;
      limit_reached  <= reached;
      produced_count <= count_inc_ext[LIMIT_W-1:0];
      run_last       <= (state == S_LIT) || copy_done;
    end
  end

  a_stopped_sticks: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stopped cleared without reset");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(RING_SIZE))
    else $error("fill count beyond ring size");

  a_copy_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_DATA) |-> (rem != '0))
    else $error("copy running with no bytes left");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    emit_en |=> (byte_count == $past(byte_count) + COUNT_BITS'(1)))
    else $error("byte count did not advance on emit");

  a_no_emit_stopped: assert property (@(posedge clk) disable iff (rst)
    (stopped && state == S_IDLE) |=> !emit_en)
    else $error("emit after decoder stopped");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// testbench for the lzss ring decoder: directed and random streams checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lzss_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 48;
  localparam int TAIL_CYCLES   = 60;
  localparam int TIMEOUT_NS    = 3_000_000;
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               run_last;
    logic               limit_reached;
    logic [LIMIT_W-1:0] produced_count;
  } decoded_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = 8'h00;
  logic               last_input = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_byte;
  logic               run_last;
  logic               limit_reached;
  logic [LIMIT_W-1:0] produced_count;
  logic               output_limit_we = 1'b0;
  logic [LIMIT_W-1:0] output_limit_wdata = '0;

  // decoder state as the predictor sees it
  logic [7:0]         hist_ring [RING_SIZE];
  logic [RING_AW-1:0] hist_wpos;
  logic [8:0]         flag_bits;
  logic [1:0]         phase;
  logic [7:0]         low_byte;
  logic [LIMIT_W-1:0] out_count;
  logic               halted;
  logic [LIMIT_W-1:0] limit_now;

  decoded_t expected_bytes [$];
  int fail_count = 0;
  int items_sent = 0;
  int hold_req = 0;
  bit steady = 1'b0;

  lzss_ring_decoder dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .last_input         (last_input),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .run_last           (run_last),
    .limit_reached      (limit_reached),
    .produced_count     (produced_count),
    .output_limit_we    (output_limit_we),
    .output_limit_wdata (output_limit_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void reset_predictor();
    for (int i = 0; i < RING_SIZE; i++) hist_ring[i] = 8'h00;
    hist_wpos = RING_START;
    flag_bits = '0;
    phase = PH_FLAG;
    low_byte = 8'h00;
    out_count = '0;
    halted = 1'b0;
    limit_now = LIMIT_TOP;
  endfunction

  function automatic decoded_t emit_decoded(input logic [7:0] b);
    decoded_t r;
    hist_ring[hist_wpos] = b;
    hist_wpos = hist_wpos + RING_AW'(1);
    out_count = out_count + LIMIT_W'(1);
    r.out_byte = b;
    r.run_last = 1'b0;
    // count width equals the limit width, so the limit needs no clamp
    r.limit_reached = (out_count >= limit_now);
    r.produced_count = out_count;
    if (r.limit_reached) halted = 1'b1;
    return r;
  endfunction

  function automatic void advance_token();
    flag_bits = flag_bits >> 1;
    phase = (flag_bits <= 9'd1) ? PH_FLAG : PH_TOKEN;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    decoded_t step_out [MAX_COPY];
    int n;
    int len;
    logic [RING_AW-1:0] src;
    n = 0;
    if (halted) return;
    if (out_count >= limit_now) begin
      halted = 1'b1;
      return;
    end
    case (phase)
      PH_TOKEN: begin
        if (flag_bits[0]) begin
          step_out[0] = emit_decoded(b);
          n = 1;
          advance_token();
        end else begin
          low_byte = b;
          phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        src = {b[7:4], low_byte};
        len = int'(b[3:0]) + MIN_COPY;
        // each read sees the bytes written earlier in the same copy
        while (n < len && !halted) begin
          step_out[n] = emit_decoded(hist_ring[src]);
          src = src + RING_AW'(1);
          n = n + 1;
        end
        advance_token();
      end
      default: begin
        flag_bits = {1'b1, b};
        phase = PH_TOKEN;
      end
    endcase
    if (n > 0) step_out[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) expected_bytes.push_back(step_out[k]);
    if (last) halted = 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : check_out
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t ns: item out_byte %0h count %0h with none expected", $time,
                 out_byte, produced_count);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
        check_field("run_last", 32'(want.run_last), 32'(run_last));
        check_field("limit_reached", 32'(want.limit_reached), 32'(limit_reached));
        check_field("produced_count", 32'(want.produced_count), 32'(produced_count));
      end
    end
  end

  initial begin : receiver
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_req != served) begin
        served = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  // valid stays high after the accepting edge; any wait must lower it first
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    last_input <= last;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, last);
    items_sent++;
  endtask

  task automatic drain_expected();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    drain_expected();
    // a flag byte or low byte gives no item, so let the block settle
    repeat (SETTLE_CYCLES) @(posedge clk);
    output_limit_we <= 1'b1;
    output_limit_wdata <= value;
    @(posedge clk);
    output_limit_we <= 1'b0;
    limit_now = value;
  endtask

  task automatic finish_token();
    while (phase == PH_TOKEN || phase == PH_HIGH) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_token_group(input bit long_refs);
    logic [7:0] flags;
    logic [RING_AW-1:0] src;
    logic [3:0] len_code;
    finish_token();
    flags = 8'($urandom);
    send_byte(flags, 1'b0);
    for (int k = 0; k < 8; k++) begin
      if (flags[k]) begin
        send_byte(8'($urandom), 1'b0);
      end else begin
        // mostly recent history, often overlapping the copy itself
        if ($urandom_range(3) == 0) src = RING_AW'($urandom);
        else src = hist_wpos - RING_AW'($urandom_range(1, 40));
        len_code = long_refs ? 4'hF : 4'($urandom);
        send_byte(src[7:0], 1'b0);
        send_byte({src[11:8], len_code}, 1'b0);
      end
    end
  endtask

  task automatic test_reset_limit();
    write_limit(LIMIT_TOP);
  endtask

  task automatic test_directed_tokens();
    // six literals then two references
    send_byte(8'h3F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    // shortest copy from the ring start
    send_byte(8'hEE, 1'b0);
    send_byte(8'hF0, 1'b0);
    // longest copy one byte behind the writer, write position wraps to zero
    send_byte(8'hF6, 1'b0);
    send_byte(8'hFF, 1'b0);
    // four references then four literals
    send_byte(8'hF0, 1'b0);
    // never written area reads zero
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0C, 1'b0);
    // read position wraps from the top of the ring
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hEF, 1'b0);
  endtask

  task automatic test_random_streams(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      // the last quarter runs with no idling on either side
      steady = (stop_at - items_sent) < count / 4;
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      else send_token_group($urandom_range(3) == 0);
    end
    steady = 1'b0;
  endtask

  task automatic test_output_hold_off();
    hold_req++;
    steady = 1'b1;
    send_token_group(1'b1);
    send_token_group(1'b1);
    steady = 1'b0;
  endtask

  task automatic test_sender_pause();
    drain_expected();
    repeat ($urandom_range(5, 30)) @(posedge clk);
    send_token_group(1'b0);
    write_limit(24'd100000);
    send_token_group(1'b0);
    send_token_group(1'b1);
  endtask

  task automatic test_limit_mid_copy();
    finish_token();
    write_limit(out_count + 24'd7);
    send_byte(8'h00, 1'b0);
    // a full length copy that the limit cuts after seven items
    send_byte(hist_wpos[7:0] - 8'd2, 1'b0);
    send_byte({hist_wpos[11:8], 4'hF}, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
  endtask

  task automatic test_stopped_decoder();
    write_limit('0);
    for (int k = 0; k < 6; k++) send_byte(8'($urandom), (k == 2) || 1'($urandom));
    // raising the limit does not restart a stopped decoder
    write_limit(LIMIT_TOP);
    for (int k = 0; k < 6; k++) send_byte(8'($urandom), 1'($urandom));
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_limit();
    test_directed_tokens();
    test_random_streams(20);
    test_output_hold_off();
    test_sender_pause();
    test_limit_mid_copy();
    test_stopped_decoder();
    drain_expected();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("%0t ns: timeout with %0d items still expected", $time, expected_bytes.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
